// ===== design/cail_pkg.sv =====
package cail_pkg;

    // Field widths of one word on each channel
    localparam int ID_W      = 32;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 4;
    localparam int SLOT_W    = 6;
    localparam int DEF_SLOTS = 64;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PRESENT = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_ENROLLED = 4'd0;
    localparam logic [STAT_W-1:0] ST_MASTER   = 4'd1;
    localparam logic [STAT_W-1:0] ST_GRANTED  = 4'd2;
    localparam logic [STAT_W-1:0] ST_DENIED   = 4'd3;
    localparam logic [STAT_W-1:0] ST_ADDED    = 4'd4;
    localparam logic [STAT_W-1:0] ST_ALREADY  = 4'd5;
    localparam logic [STAT_W-1:0] ST_DELETED  = 4'd6;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 4'd7;
    localparam logic [STAT_W-1:0] ST_FULL     = 4'd8;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 4'd9;

    // Table update applied when a result is committed
    typedef logic [2:0] t_act;
    localparam t_act ACT_NONE   = 3'd0;
    localparam t_act ACT_ENROLL = 3'd1;
    localparam t_act ACT_CLEAR  = 3'd2;
    localparam t_act ACT_ADD    = 3'd3;
    localparam t_act ACT_DEL    = 3'd4;

    // Source of the reported slot index
    typedef logic [1:0] t_slot_src;
    localparam t_slot_src SLOT_ZERO = 2'd0;
    localparam t_slot_src SLOT_HIT  = 2'd1;
    localparam t_slot_src SLOT_WR   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      scan_start;
        logic      scan_run;
        logic      commit;
        t_act      act;
        t_slot_src slot_src;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            master_vld;
        logic            id_zero;
        logic            id_is_master;
        logic            used_zero;
        logic            used_full;
        logic            scan_done;
        logic            hit;
        logic            free_vld;
    } t_dp_sts;

endpackage

// ===== design/card_id_allowlist_table.sv =====
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_opcode, i_card_id
// output    out        o_valid / i_stall   o_status, o_slot_index
//
// A word passes through a check state, an optional table walk and a commit
// state; the walk reads one slot a cycle from the single-read slot memory.
// Reset is synchronous and active low; no clearing pass is needed, slots
// above the used count are never read. A new word is taken while a result
// still waits in the output register; a stalled output holds the finished
// next result in the commit state.
module card_id_allowlist_table #(
    parameter int SLOTS = cail_pkg::DEF_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cail_pkg::OP_W-1:0]   i_opcode,
    input  logic [cail_pkg::ID_W-1:0]   i_card_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cail_pkg::STAT_W-1:0] o_status,
    output logic [cail_pkg::SLOT_W-1:0] o_slot_index
);
    import cail_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence control
    cail_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    // Table storage and slot walk
    cail_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_opcode),
        .i_card_id    (i_card_id),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_slot_index (o_slot_index)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted twice in a row");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_EMPTY))
        else $error("status code out of range");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ENROLLED || o_status == ST_MASTER ||
                     o_status == ST_DENIED || o_status == ST_NOTFOUND ||
                     o_status == ST_FULL || o_status == ST_EMPTY))
        |-> (o_slot_index == '0))
        else $error("slot index set for a status without a slot");

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || !i_stall))
        else $error("result committed over a waiting result");
`endif

endmodule

// ===== design/cail_dp.sv =====
module cail_dp #(
    parameter int SLOTS = cail_pkg::DEF_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cail_pkg::OP_W-1:0]   i_opcode,
    input  logic [cail_pkg::ID_W-1:0]   i_card_id,
    input  cail_pkg::t_dp_cmd           i_cmd,
    output cail_pkg::t_dp_sts           o_sts,
    output logic [cail_pkg::SLOT_W-1:0] o_slot_index
);
    import cail_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [ID_W-1:0]   r_mem [SLOTS];
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [ID_W-1:0]   r_master_id;
    logic              r_master_vld;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_rd_k;
    logic [IW-1:0]     r_cmp_k;
    logic              r_cmp_vld;
    logic [ID_W-1:0]   r_rd_data;
    logic              r_hit;
    logic [IW-1:0]     r_hit_k;
    logic              r_free_vld;
    logic [IW-1:0]     r_free_k;
    logic              r_scan_done;
    logic [SLOT_W-1:0] r_slot;

    logic              rd_en;
    logic              cmp_act;
    logic              cmp_last;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     add_addr;
    logic [ID_W-1:0]   wr_data;

    // Walk the used slots one read a cycle until a match or the last slot
    assign rd_en    = i_cmd.scan_run && !r_scan_done && (r_rd_k < r_used);
    assign cmp_act  = i_cmd.scan_run && !r_scan_done && r_cmp_vld;
    assign cmp_last = (CW'(r_cmp_k) == (r_used - CW'(1)));

    // Pick the write port address and data for the committed update
    assign add_addr = r_free_vld ? r_free_k : r_used[IW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = add_addr;
        wr_data = r_id;
        if (i_cmd.commit && i_cmd.act == ACT_ADD) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit && i_cmd.act == ACT_DEL) begin
            wr_en   = 1'b1;
            wr_addr = r_hit_k;
            wr_data = '0;
        end
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_k[IW-1:0]];
        end
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_id <= i_card_id;
        end
    end

    // Scan control and match tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_k      <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free_vld  <= 1'b0;
            r_scan_done <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_k      <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free_vld  <= 1'b0;
            r_scan_done <= (r_used == '0);
        end else begin
            r_cmp_vld <= rd_en;
            if (rd_en) begin
                r_rd_k <= r_rd_k + CW'(1);
            end
            if (cmp_act) begin
                if (r_rd_data == r_id && r_id != '0) begin
                    r_hit       <= 1'b1;
                    r_scan_done <= 1'b1;
                end
                if (r_rd_data == '0 && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
                if (cmp_last) begin
                    r_scan_done <= 1'b1;
                end
            end
        end
    end

    // Hold slot numbers seen by the compare stage
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmp_k <= r_rd_k[IW-1:0];
        end
        if (cmp_act && r_rd_data == r_id && !r_hit) begin
            r_hit_k <= r_cmp_k;
        end
        if (cmp_act && r_rd_data == '0 && !r_free_vld) begin
            r_free_k <= r_cmp_k;
        end
    end

    // Apply master enrollment, clear and append on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_vld <= 1'b0;
            r_used       <= '0;
        end else if (i_cmd.commit) begin
            case (i_cmd.act)
                ACT_ENROLL: r_master_vld <= 1'b1;
                ACT_CLEAR:  r_used <= '0;
                ACT_ADD: begin
                    if (!r_free_vld) begin
                        r_used <= r_used + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && i_cmd.act == ACT_ENROLL) begin
            r_master_id <= r_id;
        end
    end

    // Register the reported slot index
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (i_cmd.slot_src)
                SLOT_HIT: r_slot <= SLOT_W'(r_hit_k);
                SLOT_WR:  r_slot <= SLOT_W'(add_addr);
                default:  r_slot <= '0;
            endcase
        end
    end

    assign o_slot_index = r_slot;

    assign o_sts.op           = r_op;
    assign o_sts.master_vld   = r_master_vld;
    assign o_sts.id_zero      = (r_id == '0);
    assign o_sts.id_is_master = (r_id == r_master_id);
    assign o_sts.used_zero    = (r_used == '0);
    assign o_sts.used_full    = (r_used == CW'(SLOTS));
    assign o_sts.scan_done    = r_scan_done;
    assign o_sts.hit          = r_hit;
    assign o_sts.free_vld     = r_free_vld;

endmodule

// ===== design/cail_ctrl.sv =====
module cail_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cail_pkg::STAT_W-1:0] o_status,
    input  cail_pkg::t_dp_sts           i_sts,
    output cail_pkg::t_dp_cmd           o_cmd
);
    import cail_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [STAT_W-1:0] r_pend, n_pend;
    t_act              r_act, n_act;
    t_slot_src         r_src, n_src;
    logic              r_out_vld, n_out_vld;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic              out_free;

    assign out_free = !r_out_vld || !i_stall;

    // Sequence one word: check, optional slot walk, then commit
    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_act        = r_act;
        n_src        = r_src;
        n_out_vld    = r_out_vld && i_stall;
        n_out_status = r_out_status;
        o_cmd        = '0;
        o_cmd.act      = r_act;
        o_cmd.slot_src = r_src;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                n_act   = ACT_NONE;
                n_src   = SLOT_ZERO;
                if (!i_sts.master_vld) begin
                    if (i_sts.id_zero) begin
                        n_pend = ST_DENIED;
                    end else begin
                        n_pend = ST_ENROLLED;
                        n_act  = ACT_ENROLL;
                    end
                end else begin
                    unique case (i_sts.op) inside
                        OP_PRESENT, OP_ADD: begin
                            if (i_sts.id_is_master) begin
                                n_pend = ST_MASTER;
                            end else if (i_sts.id_zero) begin
                                n_pend = ST_DENIED;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            if (i_sts.used_zero) begin
                                n_pend = ST_EMPTY;
                            end else if (i_sts.id_is_master) begin
                                n_pend = ST_MASTER;
                            end else if (i_sts.id_zero) begin
                                n_pend = ST_NOTFOUND;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        default: begin
                            n_pend = ST_EMPTY;
                            n_act  = ACT_CLEAR;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                    unique case (i_sts.op)
                        OP_PRESENT: begin
                            n_pend = i_sts.hit ? ST_GRANTED : ST_DENIED;
                            n_src  = i_sts.hit ? SLOT_HIT : SLOT_ZERO;
                        end
                        OP_ADD: begin
                            if (i_sts.hit) begin
                                n_pend = ST_ALREADY;
                                n_src  = SLOT_HIT;
                            end else if (i_sts.free_vld || !i_sts.used_full) begin
                                n_pend = ST_ADDED;
                                n_act  = ACT_ADD;
                                n_src  = SLOT_WR;
                            end else begin
                                n_pend = ST_FULL;
                            end
                        end
                        default: begin
                            if (i_sts.hit) begin
                                n_pend = ST_DELETED;
                                n_act  = ACT_DEL;
                                n_src  = SLOT_HIT;
                            end else begin
                                n_pend = ST_NOTFOUND;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_vld    = 1'b1;
                    n_out_status = r_pend;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_act     <= ACT_NONE;
            r_src     <= SLOT_ZERO;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_act     <= n_act;
            r_src     <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_status = r_out_status;

endmodule

// ===== test/tb_card_id_allowlist_table.sv =====
module tb_card_id_allowlist_table;
    import cail_pkg::*;

    localparam int TAB_SLOTS   = DEF_SLOTS;
    localparam int POOL_N      = 100;
    localparam int RANDOM_N    = 1950;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 150;
    localparam logic [ID_W-1:0] MASTER_CARD = 32'hFFFF_FFFF;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        bit              drain;
    } t_card_word;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } t_card_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic [OP_W-1:0]   i_opcode     = '0;
    logic [ID_W-1:0]   i_card_id    = '0;
    logic              i_stall      = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [SLOT_W-1:0] o_slot_index;

    // Card words waiting to be sent and results owed by the table
    t_card_word   card_word_q[$];
    t_card_result status_due_q[$];

    // Shadow copy of the access table
    logic [ID_W-1:0] shadow_master;
    bit              shadow_master_vld;
    logic [ID_W-1:0] shadow_slots[TAB_SLOTS];
    int              shadow_used;

    logic [ID_W-1:0] card_pool[POOL_N];

    int err_cnt    = 0;
    int idle_cnt   = 0;
    bit timed_out  = 1'b0;
    int burst_left = 8;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_len  = 0;
    int cyc_cnt    = 0;

    card_id_allowlist_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_card_id    (i_card_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_error(string msg);
        if (err_cnt < 50)
            $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    task automatic push_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id, bit drain = 1'b0);
        t_card_word w;
        w.op    = op;
        w.id    = id;
        w.drain = drain;
        card_word_q.push_back(w);
    endtask

    function automatic int lookup_card(logic [ID_W-1:0] id);
        if (id == '0)
            return -1;
        for (int k = 0; k < shadow_used && k < TAB_SLOTS; k++)
            if (shadow_slots[k] == id)
                return k;
        return -1;
    endfunction

    // Apply one card word to the shadow table and queue the owed result
    function automatic void predict_card_result(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        int           hit;
        int           k;
        t_card_result r;
        r.status = ST_DENIED;
        r.slot   = '0;
        if (!shadow_master_vld) begin
            if (id != '0) begin
                shadow_master     = id;
                shadow_master_vld = 1'b1;
                r.status          = ST_ENROLLED;
            end
        end else begin
            case (op)
                OP_PRESENT: begin
                    hit = lookup_card(id);
                    if (id == shadow_master) begin
                        r.status = ST_MASTER;
                    end else if (hit >= 0) begin
                        r.status = ST_GRANTED;
                        r.slot   = hit[SLOT_W-1:0];
                    end
                end
                OP_ADD: begin
                    hit = lookup_card(id);
                    if (id == shadow_master) begin
                        r.status = ST_MASTER;
                    end else if (id == '0) begin
                        r.status = ST_DENIED;
                    end else if (hit >= 0) begin
                        r.status = ST_ALREADY;
                        r.slot   = hit[SLOT_W-1:0];
                    end else begin
                        // First hole below the used count, else append
                        k = 0;
                        while (k < shadow_used && shadow_slots[k] != '0)
                            k++;
                        if (k < shadow_used) begin
                            shadow_slots[k] = id;
                            r.status        = ST_ADDED;
                            r.slot          = k[SLOT_W-1:0];
                        end else if (shadow_used < TAB_SLOTS) begin
                            shadow_slots[shadow_used] = id;
                            r.status                  = ST_ADDED;
                            r.slot                    = shadow_used[SLOT_W-1:0];
                            shadow_used++;
                        end else begin
                            r.status = ST_FULL;
                        end
                    end
                end
                OP_DELETE: begin
                    hit = lookup_card(id);
                    if (shadow_used == 0) begin
                        r.status = ST_EMPTY;
                    end else if (id == shadow_master) begin
                        r.status = ST_MASTER;
                    end else if (hit >= 0) begin
                        shadow_slots[hit] = '0;
                        r.status          = ST_DELETED;
                        r.slot            = hit[SLOT_W-1:0];
                    end else begin
                        r.status = ST_NOTFOUND;
                    end
                end
                default: begin
                    foreach (shadow_slots[k])
                        shadow_slots[k] = '0;
                    shadow_used = 0;
                    r.status    = ST_EMPTY;
                end
            endcase
        end
        status_due_q.push_back(r);
    endfunction

    function automatic logic [ID_W-1:0] pick_card();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78)
            return card_pool[$urandom_range(0, POOL_N - 1)];
        else if (r < 84)
            return MASTER_CARD;
        else if (r < 89)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_PRESENT;
        else if (r < 72)
            return OP_ADD;
        else if (r < 97)
            return OP_DELETE;
        return OP_CLEAR;
    endfunction

    // Driver: send queued words in bursts, hold a stalled word steady
    always @(posedge i_clk) begin
        bit         slot_free;
        t_card_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            slot_free = !i_valid || !o_stall;
            if (i_valid && !o_stall)
                predict_card_result(i_opcode, i_card_id);
            if (slot_free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (card_word_q.size() != 0 &&
                             (!card_word_q[0].drain || status_due_q.size() == 0)) begin
                    nxt = card_word_q.pop_front();
                    i_opcode  <= nxt.op;
                    i_card_id <= nxt.id;
                    i_valid   <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word and stall on a changing pattern
    always @(posedge i_clk) begin
        t_card_result want;
        bit           stall_nxt;
        cyc_cnt++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_due_q.size() == 0) begin
                flag_error($sformatf("unexpected result status=%0d slot=%0d",
                                     o_status, o_slot_index));
            end else begin
                want = status_due_q.pop_front();
                if (o_status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_slot_index !== want.slot)
                    flag_error($sformatf("slot_index %0d, expected %0d",
                                         o_slot_index, want.slot));
            end
        end
        if (stall_len <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_len  = $urandom_range(20, 300);
        end
        stall_len--;
        case (stall_mode)
            0:       stall_nxt = 1'b0;
            1:       stall_nxt = ($urandom_range(0, 3) == 0);
            2:       stall_nxt = ($urandom_range(0, 3) != 0);
            default: stall_nxt = cyc_cnt[2];
        endcase
        i_stall <= stall_nxt;
    end

    // Watchdog: count cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial begin
        int  kind;
        int  n;
        int  base;
        int  rnd_cnt;
        bit  dup;
        logic [ID_W-1:0] cand;

        shadow_master     = '0;
        shadow_master_vld = 1'b0;
        shadow_used       = 0;
        foreach (shadow_slots[k])
            shadow_slots[k] = '0;

        // Distinct nonzero cards, none equal to the master
        for (int p = 0; p < POOL_N; p++) begin
            do begin
                cand = $urandom;
                dup  = (cand == '0) || (cand == MASTER_CARD);
                for (int q = 0; q < p; q++)
                    if (card_pool[q] == cand)
                        dup = 1'b1;
            end while (dup);
            card_pool[p] = cand;
        end

        // Zero card while no master, then enrollment through an add
        push_word(OP_PRESENT, 32'h0000_0000);
        push_word(OP_DELETE,  32'h0000_0000);
        push_word(OP_ADD,     MASTER_CARD);
        push_word(OP_PRESENT, MASTER_CARD);
        push_word(OP_ADD,     MASTER_CARD);
        // Delete on an empty table wins over the master test
        push_word(OP_DELETE,  MASTER_CARD);
        push_word(OP_DELETE,  32'h0000_0001);
        push_word(OP_ADD,     32'h0000_0000);
        push_word(OP_ADD,     32'h0000_0001);
        push_word(OP_ADD,     32'h8000_0000);
        push_word(OP_ADD,     32'h0000_0001);
        push_word(OP_PRESENT, 32'h0000_0001);
        push_word(OP_PRESENT, 32'h0000_0000);
        push_word(OP_PRESENT, 32'h1234_5678);
        push_word(OP_DELETE,  MASTER_CARD);
        push_word(OP_DELETE,  32'h0000_0000);
        push_word(OP_DELETE,  32'h1234_5678);
        push_word(OP_DELETE,  32'h0000_0001);
        push_word(OP_PRESENT, 32'h0000_0001);
        // Refill the hole left by the delete
        push_word(OP_ADD,     32'h1234_5678);
        push_word(OP_PRESENT, 32'h8000_0000);
        push_word(OP_CLEAR,   32'h0000_0000, 1'b1);
        push_word(OP_DELETE,  32'h1234_5678);
        push_word(OP_PRESENT, 32'h1234_5678);
        push_word(OP_ADD,     32'h7FFF_FFFF);

        // Random phases: fills up to full, mixed traffic, delete runs, clears, noise
        rnd_cnt = 0;
        while (rnd_cnt < RANDOM_N) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    n    = $urandom_range(30, 80);
                    base = $urandom_range(0, POOL_N - 1);
                    for (int j = 0; j < n; j++) begin
                        if ($urandom_range(0, 7) == 0)
                            push_word(OP_PRESENT, pick_card(), $urandom_range(0, 149) == 0);
                        else
                            push_word(OP_ADD, card_pool[(base + j) % POOL_N],
                                      $urandom_range(0, 149) == 0);
                    end
                end
                7: begin
                    n = $urandom_range(1, 8);
                    push_word(OP_CLEAR, $urandom, 1'($urandom_range(0, 1)));
                    for (int j = 0; j < n; j++)
                        push_word($urandom_range(0, 1) ? OP_PRESENT : OP_DELETE, pick_card());
                    n = n + 1;
                end
                8: begin
                    n = $urandom_range(5, 20);
                    for (int j = 0; j < n; j++)
                        push_word(OP_W'($urandom_range(0, 3)), $urandom);
                end
                9: begin
                    n = $urandom_range(10, 50);
                    for (int j = 0; j < n; j++)
                        push_word(OP_DELETE, pick_card(), $urandom_range(0, 149) == 0);
                end
                default: begin
                    n = $urandom_range(10, 60);
                    for (int j = 0; j < n; j++)
                        push_word(pick_op(), pick_card(), $urandom_range(0, 149) == 0);
                end
            endcase
            rnd_cnt += n;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait ((card_word_q.size() == 0 && !i_valid && status_due_q.size() == 0) || timed_out);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge i_clk);
        if (status_due_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", status_due_q.size()));
        if (!timed_out && err_cnt == 0)
            $display("tb_card_id_allowlist_table passed");
        else
            $display("tb_card_id_allowlist_table failed");
        $finish;
    end

endmodule
